@@ rtl/stmr_pkg.sv @@
`timescale 1ns / 1ps

package stmr_pkg;

   // Default sizes of the stores and the screen.
   localparam int TILE_DIM_DEF   = 16;
   localparam int MAP_CELLS_DEF  = 16384;
   localparam int TILE_COUNT_DEF = 256;
   localparam int SCREEN_DIM_DEF = 1024;

   // Field widths.
   localparam int CMD_W      = 2;
   localparam int SCREEN_W   = 10;
   localparam int MAP_ADDR_W = 14;
   localparam int TILE_ID_W  = 8;
   localparam int TILE_POS_W = 4;
   localparam int DATA_W     = 8;
   localparam int VIEW_W     = 12;
   localparam int DIM_W      = 8;

   // World coordinates hold a view offset plus a screen position.
   localparam int WORLD_W = VIEW_W + 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = CMD_W;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USED_W = DATA_W + 2 * SCREEN_W;
   localparam int RSP_USER_W = 1;

   localparam int FIFO_DEPTH = 16;

   localparam logic [DIM_W-1:0] MAP_DIM_RESET = 8'd128;

   typedef enum logic [CMD_W-1:0] {
      OP_MAP_WRITE  = 2'd0,
      OP_TILE_WRITE = 2'd1,
      OP_RENDER     = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VIEW_X      = 2'd0,
      CSR_VIEW_Y      = 2'd1,
      CSR_MAP_COLUMNS = 2'd2,
      CSR_MAP_ROWS    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SCREEN_W-1:0] out_y;
      logic [SCREEN_W-1:0] out_x;
      logic [DATA_W-1:0]   pixel;
      logic                outside_map;
   } rsp_entry_type;

endpackage

@@ rtl/scrolling_tilemap_renderer_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req_      in         tvalid / tready    tuser: cmd; tdata: screen, map and tile fields
// rsp_      out        tvalid / tready    tuser: outside_map; tdata: pixel, out_x, out_y
// csr_      in         valid / ready      index, wdata (ready is always high)
//
// One item enters per cycle while req_tready is high. A render result is offered after
// the address math, the map read, the tile address, the tile read and the write into
// the result queue.
// Results land in a 16-entry queue; req_tready drops only while 16 results are owed.
// Reset is synchronous and clears the registers, the pipeline and the queue; the map
// and tile memories are not cleared and hold garbage until written.
module scrolling_tilemap_renderer_top #(
   parameter int TILE_DIM   = stmr_pkg::TILE_DIM_DEF,
   parameter int MAP_CELLS  = stmr_pkg::MAP_CELLS_DEF,
   parameter int TILE_COUNT = stmr_pkg::TILE_COUNT_DEF,
   parameter int SCREEN_DIM = stmr_pkg::SCREEN_DIM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // screen_x, screen_y, map_addr, tile_id, tile_row, tile_col, wdata, zero fill
   input  logic [stmr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd
   input  logic [stmr_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel, out_x, out_y, zero fill
   output logic [stmr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // outside_map
   output logic [stmr_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [stmr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [stmr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int WORLD_W      = stmr_pkg::WORLD_W;
   localparam int TILE_AREA    = TILE_DIM * TILE_DIM;
   localparam int BITMAP_DEPTH = TILE_COUNT * TILE_AREA;
   localparam int MAW          = $clog2(MAP_CELLS);
   localparam int BMW          = $clog2(BITMAP_DEPTH);
   localparam int OFS_W        = $clog2(TILE_DIM);
   localparam int TOFF_W       = $clog2(TILE_AREA);
   localparam int CELL_W       = WORLD_W + stmr_pkg::DIM_W + 1;
   localparam int PROD_W       = 2 * WORLD_W;
   localparam int RECIP        = (1 << WORLD_W) / TILE_DIM;
   localparam int PTR_W        = $clog2(stmr_pkg::FIFO_DEPTH);
   localparam int CNT_W        = $clog2(stmr_pkg::FIFO_DEPTH + 1);

   typedef struct packed {
      stmr_pkg::op_type                  kind;
      logic [stmr_pkg::SCREEN_W-1:0]     sx;
      logic [stmr_pkg::SCREEN_W-1:0]     sy;
      logic [stmr_pkg::MAP_ADDR_W-1:0]   map_addr;
      logic [BMW-1:0]                    tw_addr;
      logic [stmr_pkg::DATA_W-1:0]       wdata;
   } pass_type;

   // Request fields.
   logic [stmr_pkg::SCREEN_W-1:0]   req_screen_x;
   logic [stmr_pkg::SCREEN_W-1:0]   req_screen_y;
   logic [stmr_pkg::MAP_ADDR_W-1:0] req_map_addr;
   logic [stmr_pkg::TILE_ID_W-1:0]  req_tile_id;
   logic [stmr_pkg::TILE_POS_W-1:0] req_tile_row;
   logic [stmr_pkg::TILE_POS_W-1:0] req_tile_col;
   logic [stmr_pkg::DATA_W-1:0]     req_wdata;
   logic                            req_accept;

   // Configuration.
   logic [stmr_pkg::VIEW_W-1:0] view_x_ff;
   logic [stmr_pkg::VIEW_W-1:0] view_y_ff;
   logic [stmr_pkg::DIM_W-1:0]  map_columns_ff;
   logic [stmr_pkg::DIM_W-1:0]  map_rows_ff;

   // Pipeline.
   pass_type             a_pass_in, a_pass_ff, b_pass_ff, c_pass_ff, d_pass_ff;
   pass_type             e_pass_ff, f_pass_ff, g_pass_ff;
   logic [WORLD_W-1:0]   a_wx_in, a_wy_in, a_wx_ff, a_wy_ff;
   logic [PROD_W-1:0]    prod_x, prod_y;
   logic [WORLD_W-1:0]   b_wx_ff, b_wy_ff, b_qx_ff, b_qy_ff;
   logic [WORLD_W-1:0]   rem_x, rem_y;
   logic [WORLD_W-1:0]   c_cx_in, c_cy_in, c_cx_ff, c_cy_ff;
   logic [OFS_W-1:0]     c_ox_in, c_oy_in, c_ox_ff, c_oy_ff;
   logic                 d_out_in, d_out_ff;
   logic [CELL_W-1:0]    d_cell_in, d_cell_ff;
   logic [TOFF_W-1:0]    d_toff_in, d_toff_ff;
   logic                 d_outside;
   logic                 e_outside_ff;
   logic [TOFF_W-1:0]    e_toff_ff;
   logic [stmr_pkg::DATA_W-1:0] map_q_ff;
   logic                 e_tile_ok;
   logic [BMW-1:0]       f_taddr_in, f_taddr_ff;
   logic                 f_zero_ff, f_outside_ff;
   logic                 g_zero_ff, g_outside_ff;
   logic [stmr_pkg::DATA_W-1:0] tile_q_ff;

   // Memories.
   logic [stmr_pkg::DATA_W-1:0] map_mem  [MAP_CELLS];
   logic [stmr_pkg::DATA_W-1:0] tile_mem [BITMAP_DEPTH];

   // Result queue.
   stmr_pkg::rsp_entry_type fifo_mem [stmr_pkg::FIFO_DEPTH];
   stmr_pkg::rsp_entry_type push_entry;
   stmr_pkg::rsp_entry_type head_entry;
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in, reserved_ff, reserved_in;
   logic             push, pop, reserve;

   assign req_screen_x = req_tdata[9:0];
   assign req_screen_y = req_tdata[19:10];
   assign req_map_addr = req_tdata[33:20];
   assign req_tile_id  = req_tdata[41:34];
   assign req_tile_row = req_tdata[45:42];
   assign req_tile_col = req_tdata[49:46];
   assign req_wdata    = req_tdata[57:50];

   assign req_tready = reserved_ff < CNT_W'(stmr_pkg::FIFO_DEPTH);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         view_x_ff      <= '0;
         view_y_ff      <= '0;
         map_columns_ff <= stmr_pkg::MAP_DIM_RESET;
         map_rows_ff    <= stmr_pkg::MAP_DIM_RESET;
      end else if (csr_valid) begin
         case (stmr_pkg::csr_index_type'(csr_index))
            stmr_pkg::CSR_VIEW_X:      view_x_ff      <= csr_wdata[stmr_pkg::VIEW_W-1:0];
            stmr_pkg::CSR_VIEW_Y:      view_y_ff      <= csr_wdata[stmr_pkg::VIEW_W-1:0];
            stmr_pkg::CSR_MAP_COLUMNS: map_columns_ff <= csr_wdata[stmr_pkg::DIM_W-1:0];
            stmr_pkg::CSR_MAP_ROWS:    map_rows_ff    <= csr_wdata[stmr_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Decode. Writes out of range and off-screen renders become bubbles here.
   always_comb begin
      a_pass_in.kind     = stmr_pkg::OP_NONE;
      a_pass_in.sx       = req_screen_x;
      a_pass_in.sy       = req_screen_y;
      a_pass_in.map_addr = req_map_addr;
      a_pass_in.wdata    = req_wdata;
      a_pass_in.tw_addr  = BMW'(req_tile_id) * BMW'(TILE_AREA)
                         + BMW'(req_tile_row) * BMW'(TILE_DIM) + BMW'(req_tile_col);
      case (stmr_pkg::op_type'(req_tuser))
         stmr_pkg::OP_MAP_WRITE: begin
            if (32'(req_map_addr) < 32'(MAP_CELLS)) begin
               a_pass_in.kind = stmr_pkg::OP_MAP_WRITE;
            end
         end
         stmr_pkg::OP_TILE_WRITE: begin
            if (32'(req_tile_id) < 32'(TILE_COUNT) && 32'(req_tile_row) < 32'(TILE_DIM)
                && 32'(req_tile_col) < 32'(TILE_DIM)) begin
               a_pass_in.kind = stmr_pkg::OP_TILE_WRITE;
            end
         end
         stmr_pkg::OP_RENDER: begin
            if (32'(req_screen_x) < 32'(SCREEN_DIM) && 32'(req_screen_y) < 32'(SCREEN_DIM)) begin
               a_pass_in.kind = stmr_pkg::OP_RENDER;
            end
         end
         default: a_pass_in.kind = stmr_pkg::OP_NONE;
      endcase
      if (!req_accept) begin
         a_pass_in.kind = stmr_pkg::OP_NONE;
      end
   end

   assign a_wx_in = WORLD_W'(view_x_ff) + WORLD_W'(req_screen_x);
   assign a_wy_in = WORLD_W'(view_y_ff) + WORLD_W'(req_screen_y);

   // Tile division by a scaled reciprocal; the estimate is low by at most one.
   assign prod_x = PROD_W'(a_wx_ff) * PROD_W'(RECIP);
   assign prod_y = PROD_W'(a_wy_ff) * PROD_W'(RECIP);

   always_comb begin
      rem_x   = b_wx_ff - b_qx_ff * WORLD_W'(TILE_DIM);
      rem_y   = b_wy_ff - b_qy_ff * WORLD_W'(TILE_DIM);
      c_cx_in = b_qx_ff;
      c_ox_in = OFS_W'(rem_x);
      c_cy_in = b_qy_ff;
      c_oy_in = OFS_W'(rem_y);
      if (rem_x >= WORLD_W'(TILE_DIM)) begin
         c_cx_in = b_qx_ff + WORLD_W'(1);
         c_ox_in = OFS_W'(rem_x - WORLD_W'(TILE_DIM));
      end
      if (rem_y >= WORLD_W'(TILE_DIM)) begin
         c_cy_in = b_qy_ff + WORLD_W'(1);
         c_oy_in = OFS_W'(rem_y - WORLD_W'(TILE_DIM));
      end
   end

   assign d_out_in  = (c_cx_ff >= WORLD_W'(map_columns_ff)) || (c_cy_ff >= WORLD_W'(map_rows_ff));
   assign d_cell_in = CELL_W'(c_cy_ff) * CELL_W'(map_columns_ff) + CELL_W'(c_cx_ff);
   assign d_toff_in = TOFF_W'(c_oy_ff) * TOFF_W'(TILE_DIM) + TOFF_W'(c_ox_ff);

   assign d_outside = d_out_ff || (d_cell_ff >= CELL_W'(MAP_CELLS));

   assign e_tile_ok  = 32'(map_q_ff) < 32'(TILE_COUNT);
   assign f_taddr_in = BMW'(map_q_ff) * BMW'(TILE_AREA) + BMW'(e_toff_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_pass_ff.kind <= stmr_pkg::OP_NONE;
         b_pass_ff.kind <= stmr_pkg::OP_NONE;
         c_pass_ff.kind <= stmr_pkg::OP_NONE;
         d_pass_ff.kind <= stmr_pkg::OP_NONE;
         e_pass_ff.kind <= stmr_pkg::OP_NONE;
         f_pass_ff.kind <= stmr_pkg::OP_NONE;
         g_pass_ff.kind <= stmr_pkg::OP_NONE;
      end else begin
         a_pass_ff <= a_pass_in;
         b_pass_ff <= a_pass_ff;
         c_pass_ff <= b_pass_ff;
         d_pass_ff <= c_pass_ff;
         e_pass_ff <= d_pass_ff;
         f_pass_ff <= e_pass_ff;
         g_pass_ff <= f_pass_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_wx_ff      <= a_wx_in;
      a_wy_ff      <= a_wy_in;
      b_wx_ff      <= a_wx_ff;
      b_wy_ff      <= a_wy_ff;
      b_qx_ff      <= prod_x[PROD_W-1:WORLD_W];
      b_qy_ff      <= prod_y[PROD_W-1:WORLD_W];
      c_cx_ff      <= c_cx_in;
      c_cy_ff      <= c_cy_in;
      c_ox_ff      <= c_ox_in;
      c_oy_ff      <= c_oy_in;
      d_out_ff     <= d_out_in;
      d_cell_ff    <= d_cell_in;
      d_toff_ff    <= d_toff_in;
      e_outside_ff <= d_outside;
      e_toff_ff    <= d_toff_ff;
      f_taddr_ff   <= f_taddr_in;
      f_zero_ff    <= e_outside_ff || !e_tile_ok;
      f_outside_ff <= e_outside_ff;
      g_zero_ff    <= f_zero_ff;
      g_outside_ff <= f_outside_ff;
   end

   // Each memory is written and read in one stage only, so accesses stay in order.
   always_ff @(posedge clock) begin
      if (d_pass_ff.kind == stmr_pkg::OP_MAP_WRITE) begin
         map_mem[MAW'(d_pass_ff.map_addr)] <= d_pass_ff.wdata;
      end
      if (d_pass_ff.kind == stmr_pkg::OP_RENDER && !d_outside) begin
         map_q_ff <= map_mem[MAW'(d_cell_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (f_pass_ff.kind == stmr_pkg::OP_TILE_WRITE) begin
         tile_mem[f_pass_ff.tw_addr] <= f_pass_ff.wdata;
      end
      if (f_pass_ff.kind == stmr_pkg::OP_RENDER && !f_zero_ff) begin
         tile_q_ff <= tile_mem[f_taddr_ff];
      end
   end

   // Result queue. A slot is reserved when an on-screen render is accepted.
   assign push    = g_pass_ff.kind == stmr_pkg::OP_RENDER;
   assign pop     = rsp_tvalid && rsp_tready;
   assign reserve = a_pass_in.kind == stmr_pkg::OP_RENDER;

   assign push_entry.out_y       = g_pass_ff.sy;
   assign push_entry.out_x       = g_pass_ff.sx;
   assign push_entry.pixel       = g_zero_ff ? '0 : tile_q_ff;
   assign push_entry.outside_map = g_outside_ff;

   assign count_in    = count_ff + CNT_W'(push) - CNT_W'(pop);
   assign reserved_in = reserved_ff + CNT_W'(reserve) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         reserved_ff <= '0;
      end else begin
         count_ff    <= count_in;
         reserved_ff <= reserved_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = fifo_mem[rd_ptr_ff];
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = {(stmr_pkg::RSP_DATA_W - stmr_pkg::RSP_USED_W)'(0),
                        head_entry.out_y, head_entry.out_x, head_entry.pixel};
   assign rsp_tuser  = head_entry.outside_map;

endmodule

@@ rtl/stmr_checker.sv @@
`timescale 1ns / 1ps

module stmr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [stmr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [stmr_pkg::RSP_USER_W-1:0] rsp_tuser
);

   // A result offered but not taken stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A cell beyond the map always renders as palette index zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[stmr_pkg::DATA_W-1:0] == '0)
      else $error("outside-map result with nonzero pixel");

   // Back-pressure on requests only arises while results are waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no result pending");

   // Reset leaves the block empty and ready.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_tready && !rsp_tvalid)
      else $error("block not empty after reset");

   // Fill bits above the packed result fields stay zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         rsp_tdata[stmr_pkg::RSP_DATA_W-1:stmr_pkg::RSP_USED_W] == '0)
      else $error("result fill bits set");

endmodule

bind scrolling_tilemap_renderer_top stmr_checker u_stmr_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int TS        = stmr_pkg::TILE_DIM_DEF;
   localparam int AREA      = TS * TS;
   localparam int PIXELS    = stmr_pkg::TILE_COUNT_DEF * AREA;
   localparam int SETTLE    = 10;
   localparam int IDLE_PCT  = 13;

   typedef struct {
      stmr_pkg::op_type cmd;
      bit [9:0]    screen_x;
      bit [9:0]    screen_y;
      bit [13:0]   map_addr;
      bit [7:0]    tile_id;
      bit [3:0]    tile_row;
      bit [3:0]    tile_col;
      bit [7:0]    wdata;
   } tile_request_type;

   typedef struct {
      bit [7:0] pixel;
      bit       outside;
      bit [9:0] x;
      bit [9:0] y;
   } pixel_result_type;

   logic                             clock = 0;
   logic                             reset = 1;
   logic                             req_tvalid = 0;
   logic                             req_tready;
   logic [stmr_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic [stmr_pkg::REQ_USER_W-1:0]  req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 0;
   logic [stmr_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [stmr_pkg::RSP_USER_W-1:0]  rsp_tuser;
   logic                             csr_valid = 0;
   logic                             csr_ready;
   logic [stmr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [stmr_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   scrolling_tilemap_renderer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow of the block: stores and registers as seen by accepted transfers.
   bit [7:0]  shadow_map [stmr_pkg::MAP_CELLS_DEF];
   bit [7:0]  shadow_tiles [PIXELS];
   bit [11:0] cfg_view_x = '0;
   bit [11:0] cfg_view_y = '0;
   bit [7:0]  cfg_cols = stmr_pkg::MAP_DIM_RESET;
   bit [7:0]  cfg_rows = stmr_pkg::MAP_DIM_RESET;

   // Stimulus side: what has been queued so far, so renders only read written entries.
   bit [7:0]  gen_map [stmr_pkg::MAP_CELLS_DEF];
   bit        map_written [stmr_pkg::MAP_CELLS_DEF];
   bit        pixel_written [PIXELS];
   int        gen_view_x = 0;
   int        gen_view_y = 0;
   int        gen_cols = int'(stmr_pkg::MAP_DIM_RESET);
   int        gen_rows = int'(stmr_pkg::MAP_DIM_RESET);
   int        hot_x;
   int        hot_y;

   tile_request_type pending_requests [$];
   pixel_result_type pixels_owed [$];
   tile_request_type req_on_bus;
   pixel_result_type seen_pixel;
   int          items_queued = 0;
   int          failures = 0;
   int          idle_pct = IDLE_PCT;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

   // Splits a world position into its map cell and the pixel offset inside the tile.
   function automatic bit locate_cell(input int wx, input int wy, input int cols,
                                      input int rows, output int cell_idx, output int offset);
      int cx;
      int cy;
      cx = wx / TS;
      cy = wy / TS;
      offset = (wy % TS) * TS + wx % TS;
      cell_idx = cy * cols + cx;
      return cx < cols && cy < rows && cell_idx < stmr_pkg::MAP_CELLS_DEF;
   endfunction

   task automatic apply_request(tile_request_type r);
      pixel_result_type res;
      int          cell_idx;
      int          offset;
      case (r.cmd)
         stmr_pkg::OP_MAP_WRITE:  shadow_map[r.map_addr] = r.wdata;
         stmr_pkg::OP_TILE_WRITE:
            shadow_tiles[r.tile_id * AREA + r.tile_row * TS + r.tile_col] = r.wdata;
         stmr_pkg::OP_RENDER: begin
            res.pixel   = '0;
            res.outside = 1'b1;
            res.x       = r.screen_x;
            res.y       = r.screen_y;
            if (locate_cell(int'(cfg_view_x) + int'(r.screen_x),
                            int'(cfg_view_y) + int'(r.screen_y),
                            int'(cfg_cols), int'(cfg_rows), cell_idx, offset)) begin
               res.outside = 1'b0;
               if (shadow_map[cell_idx] < stmr_pkg::TILE_COUNT_DEF)
                  res.pixel = shadow_tiles[shadow_map[cell_idx] * AREA + offset];
            end
            pixels_owed.push_back(res);
         end
         default: ;
      endcase
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         failures++;
      end
   endfunction

   // Driver: moves one pending request per transfer and predicts it as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            apply_request(req_on_bus);
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_on_bus = pending_requests.pop_front();
               req_tdata  <= {6'b0, req_on_bus.wdata, req_on_bus.tile_col, req_on_bus.tile_row,
                              req_on_bus.tile_id, req_on_bus.map_addr, req_on_bus.screen_y,
                              req_on_bus.screen_x};
               req_tuser  <= req_on_bus.cmd;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: tracks register writes and checks every result transfer in order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               stmr_pkg::CSR_VIEW_X:      cfg_view_x = csr_wdata;
               stmr_pkg::CSR_VIEW_Y:      cfg_view_y = csr_wdata;
               stmr_pkg::CSR_MAP_COLUMNS: cfg_cols = csr_wdata[stmr_pkg::DIM_W-1:0];
               stmr_pkg::CSR_MAP_ROWS:    cfg_rows = csr_wdata[stmr_pkg::DIM_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pixels_owed.size() == 0) begin
               $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                        $time, rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               seen_pixel = pixels_owed.pop_front();
               check_field("pixel", 32'(seen_pixel.pixel), 32'(rsp_tdata[7:0]));
               check_field("outside_map", 32'(seen_pixel.outside), 32'(rsp_tuser[0]));
               check_field("out_x", 32'(seen_pixel.x), 32'(rsp_tdata[17:8]));
               check_field("out_y", 32'(seen_pixel.y), 32'(rsp_tdata[27:18]));
            end
         end
         rsp_tready <= $urandom_range(0, 99) >= idle_pct;
      end
   end

   function automatic tile_request_type random_request(stmr_pkg::op_type op);
      tile_request_type r;
      r.cmd      = op;
      r.screen_x = 10'($urandom);
      r.screen_y = 10'($urandom);
      r.map_addr = 14'($urandom);
      r.tile_id  = 8'($urandom);
      r.tile_row = 4'($urandom);
      r.tile_col = 4'($urandom);
      r.wdata    = 8'($urandom);
      return r;
   endfunction

   task automatic queue_item(tile_request_type r);
      pending_requests.push_back(r);
      if (r.cmd != stmr_pkg::OP_NONE)
         items_queued++;
      if (r.cmd == stmr_pkg::OP_MAP_WRITE) begin
         gen_map[r.map_addr]     = r.wdata;
         map_written[r.map_addr] = 1'b1;
      end else if (r.cmd == stmr_pkg::OP_TILE_WRITE) begin
         pixel_written[r.tile_id * AREA + r.tile_row * TS + r.tile_col] = 1'b1;
      end
   endtask

   task automatic queue_map_write(int addr, int tile);
      tile_request_type r;
      r = random_request(stmr_pkg::OP_MAP_WRITE);
      r.map_addr = 14'(addr);
      r.wdata    = 8'(tile);
      queue_item(r);
   endtask

   task automatic queue_tile_write(int pos, int value);
      tile_request_type r;
      r = random_request(stmr_pkg::OP_TILE_WRITE);
      r.tile_id  = 8'(pos / AREA);
      r.tile_row = 4'((pos / TS) % TS);
      r.tile_col = 4'(pos % TS);
      r.wdata    = 8'(value);
      queue_item(r);
   endtask

   // Most cells point at a few tiles so renders keep hitting pixels already loaded.
   function automatic int pick_tile();
      if ($urandom_range(0, 99) < 75)
         return int'($urandom_range(0, 7));
      return int'($urandom_range(0, stmr_pkg::TILE_COUNT_DEF - 1));
   endfunction

   // A render first loads whatever map cell and tile pixel it would read that is not yet written.
   task automatic queue_render(int sx, int sy);
      tile_request_type r;
      int          cell_idx;
      int          offset;
      int          pos;
      r = random_request(stmr_pkg::OP_RENDER);
      r.screen_x = 10'(sx);
      r.screen_y = 10'(sy);
      if (locate_cell(gen_view_x + sx, gen_view_y + sy, gen_cols, gen_rows,
                      cell_idx, offset)) begin
         if (!map_written[cell_idx])
            queue_map_write(cell_idx, pick_tile());
         pos = gen_map[cell_idx] * AREA + offset;
         if (!pixel_written[pos])
            queue_tile_write(pos, int'($urandom_range(0, 255)));
      end
      queue_item(r);
   endtask

   // Screen coordinate that mostly lands on the map, often inside a small hot window.
   function automatic int pick_coord(int view, int cells, int hot_lo);
      int lo;
      int hi;
      lo = view;
      hi = view + stmr_pkg::SCREEN_DIM_DEF - 1;
      if (hi > cells * TS - 1)
         hi = cells * TS - 1;
      if (lo > hi || $urandom_range(0, 99) < 15)
         return int'($urandom_range(0, stmr_pkg::SCREEN_DIM_DEF - 1));
      if (hot_lo >= lo && hot_lo <= hi && $urandom_range(0, 1)) begin
         lo = hot_lo;
         if (hi > hot_lo + 47)
            hi = hot_lo + 47;
      end
      return int'($urandom_range(lo, hi)) - view;
   endfunction

   task automatic queue_random_item();
      tile_request_type r;
      if ($urandom_range(0, 99) < 75) begin
         queue_render(pick_coord(gen_view_x, gen_cols, hot_x),
                      pick_coord(gen_view_y, gen_rows, hot_y));
      end else begin
         r = random_request(stmr_pkg::op_type'($urandom_range(0, 3)));
         if (r.cmd == stmr_pkg::OP_RENDER)
            queue_render(int'(r.screen_x), int'(r.screen_y));
         else
            queue_item(r);
      end
   endtask

   task automatic write_csr(stmr_pkg::csr_index_type idx, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 12'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         stmr_pkg::CSR_VIEW_X:      gen_view_x = value;
         stmr_pkg::CSR_VIEW_Y:      gen_view_y = value;
         stmr_pkg::CSR_MAP_COLUMNS: gen_cols = value;
         stmr_pkg::CSR_MAP_ROWS:    gen_rows = value;
         default: ;
      endcase
   endtask

   // Waits until the sender is empty and every result has arrived, then lets writes settle.
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_tvalid || pixels_owed.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(int vx, int vy, int cols, int rows, int budget, int idle);
      int target;
      wait_idle();
      write_csr(stmr_pkg::CSR_VIEW_X, vx);
      write_csr(stmr_pkg::CSR_VIEW_Y, vy);
      write_csr(stmr_pkg::CSR_MAP_COLUMNS, cols);
      write_csr(stmr_pkg::CSR_MAP_ROWS, rows);
      idle_pct = idle;
      hot_x = vx + pick_coord(vx, cols, -1);
      hot_y = vy + pick_coord(vy, rows, -1);
      queue_render(0, 0);
      queue_render(stmr_pkg::SCREEN_DIM_DEF - 1, stmr_pkg::SCREEN_DIM_DEF - 1);
      target = items_queued + budget;
      while (items_queued < target)
         queue_random_item();
   endtask

   initial begin
      tile_request_type r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Extremes of the stores and screen corners at the reset register values.
      queue_tile_write(PIXELS - 1, 255);
      queue_tile_write(0, 0);
      queue_map_write(stmr_pkg::MAP_CELLS_DEF - 1, stmr_pkg::TILE_COUNT_DEF - 1);
      queue_map_write(0, 0);
      queue_render(0, 0);
      queue_render(stmr_pkg::SCREEN_DIM_DEF - 1, stmr_pkg::SCREEN_DIM_DEF - 1);
      queue_render(stmr_pkg::SCREEN_DIM_DEF - 1, 0);
      queue_render(0, stmr_pkg::SCREEN_DIM_DEF - 1);
      r = random_request(stmr_pkg::OP_NONE);
      r.screen_x = '1;
      r.screen_y = '1;
      r.map_addr = '1;
      r.tile_id  = '1;
      r.tile_row = '1;
      r.tile_col = '1;
      r.wdata    = '1;
      queue_item(r);
      queue_render(5, 7);

      // The first setting puts the last map cell at the screen origin.
      run_phase(2047, 2047, 128, 128, 120, IDLE_PCT);
      run_phase(4095, 4095, 128, 128, 60, IDLE_PCT);
      run_phase(0, 0, 1, 1, 100, IDLE_PCT);
      run_phase(100, 37, 40, 20, 150, 0);
      run_phase(0, 0, 0, 5, 40, IDLE_PCT);
      // A wide row stride pushes lower rows past the end of the map store.
      run_phase(1000, 500, 255, 128, 120, IDLE_PCT);
      run_phase(0, 0, 128, 128, 130, IDLE_PCT);
      repeat (3)
         run_phase(int'($urandom_range(0, 1500)), int'($urandom_range(0, 1500)),
                   int'($urandom_range(1, 128)), int'($urandom_range(1, 128)), 110, IDLE_PCT);
      run_phase(1, 4094, 128, 1, 60, IDLE_PCT);

      wait_idle();
      repeat (20) @(posedge clock);
      if (failures == 0 && pixels_owed.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/stmr_pkg.sv
rtl/scrolling_tilemap_renderer_top.sv
rtl/stmr_checker.sv
dv/testbench.sv
